/* rtl/bmd_pkg.sv */
// Shared types, constants and helpers for the bulk message deframer.
`timescale 1ns / 1ps

package bmd_pkg;

    // Header layout and limits.
    localparam logic [17:0] HEADER_BYTES   = 18'd12;
    localparam logic [17:0] POS_CAP        = 18'h3FFFF;
    localparam logic [31:0] MAX_PAYLOAD    = 32'd65536;
    localparam logic [7:0]  MSG_OUT_ID     = 8'd1;
    localparam logic [7:0]  MSG_IN_ID      = 8'd2;
    localparam logic [7:0]  ATTR_RSVD_MASK = 8'hFE;

    // Stream widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 17;

    // Result queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Verdict codes.
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_TOO_LONG   = 3'd2,
        ST_TRUNCATED  = 3'd3,
        ST_BAD_ALIGN  = 3'd4
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION     = 2'd0,
        CFG_MAX_PAYLOAD   = 2'd1,
        CFG_MAX_ALIGNMENT = 2'd2
    } cfg_reg_t;

    // One result transaction.
    typedef struct packed {
        logic [16:0] payload_length;
        logic        eom_attr;
        logic [7:0]  message_tag;
        status_t     status;
        logic        done_res;
        logic        payload_valid;
        logic [7:0]  payload_byte;
    } res_t;

    // The first error seen in a transfer is kept; later ones are dropped.
    function automatic status_t first_err(status_t cur, status_t code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage

/* rtl/bmd_front.sv */
// Front end: parses the header, tracks the transfer and builds result transactions.
`timescale 1ns / 1ps

module bmd_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmd_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic                             item_acc,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    input  logic [7:0]                       host_tag,
    output logic                             res_push,
    output bmd_pkg::res_t                    res
);

    // Configuration registers.
    logic        direction_reg;
    logic [16:0] max_payload_reg;
    logic [7:0]  max_alignment_reg;

    // Per-transfer state.
    logic [17:0]      pos_reg, pos_next;
    logic [7:0]       tag_reg, tag_next;
    logic [31:0]      len_reg, len_next;
    logic             eom_reg, eom_next;
    bmd_pkg::status_t err_reg, err_next;
    logic [7:0]       want_reg, want_next;

    logic pay_valid;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg     <= 1'b0;
            max_payload_reg   <= 17'd65536;
            max_alignment_reg <= 8'd3;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bmd_pkg::CFG_DIRECTION:     direction_reg     <= cfg_data[0];
                bmd_pkg::CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[16:0];
                bmd_pkg::CFG_MAX_ALIGNMENT: max_alignment_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Byte classification, header checks and the end-of-transfer verdict.
    always_comb begin
        logic [31:0] limit;
        logic [18:0] total;
        logic [18:0] content;
        logic [18:0] extra;
        logic [1:0]  pad;
        logic [7:0]  b;
        logic [7:0]  id_want;

        b       = data_byte;
        id_want = direction_reg ? bmd_pkg::MSG_IN_ID : bmd_pkg::MSG_OUT_ID;
        limit   = ({15'd0, max_payload_reg} < bmd_pkg::MAX_PAYLOAD) ?
                  {15'd0, max_payload_reg} : bmd_pkg::MAX_PAYLOAD;
        total   = '0;
        content = '0;
        extra   = '0;
        pad     = '0;

        pos_next  = pos_reg;
        tag_next  = tag_reg;
        len_next  = len_reg;
        eom_next  = eom_reg;
        err_next  = err_reg;
        want_next = want_reg;
        pay_valid = 1'b0;

        // Header fields by position; payload afterward.
        if (pos_reg == 18'd0) begin
            want_next = host_tag;
            if (b != id_want)
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_BAD_HEADER);
        end else if (pos_reg == 18'd1) begin
            tag_next = b;
            if (b == 8'd0 || (direction_reg && b != want_reg))
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_BAD_HEADER);
        end else if (pos_reg == 18'd2) begin
            if (b != ~tag_reg)
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_BAD_HEADER);
        end else if (pos_reg == 18'd3) begin
            if (b != 8'd0)
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_BAD_HEADER);
        end else if (pos_reg < 18'd8) begin
            // Little-endian length, one byte lane per position.
            case (pos_reg[1:0])
                2'd0:    len_next[7:0]   = b;
                2'd1:    len_next[15:8]  = b;
                2'd2:    len_next[23:16] = b;
                default: len_next[31:24] = b;
            endcase
        end else if (pos_reg == 18'd8) begin
            eom_next = b[0];
            if ((b & bmd_pkg::ATTR_RSVD_MASK) != 8'd0)
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_BAD_HEADER);
        end else if (pos_reg < bmd_pkg::HEADER_BYTES) begin
            if (b != 8'd0)
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_BAD_HEADER);
            if (pos_reg == bmd_pkg::HEADER_BYTES - 18'd1 && len_reg > limit)
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_TOO_LONG);
        end else if (err_reg == bmd_pkg::ST_OK &&
                     {14'd0, pos_reg - bmd_pkg::HEADER_BYTES} < len_reg) begin
            pay_valid = 1'b1;
        end

        // Saturating byte count.
        if (pos_reg != bmd_pkg::POS_CAP)
            pos_next = pos_reg + 18'd1;

        // Verdict on the last byte. With no error the length fits 17 bits.
        if (last_byte) begin
            if (pos_reg < bmd_pkg::HEADER_BYTES - 18'd1)
                err_next = bmd_pkg::first_err(err_next, bmd_pkg::ST_BAD_HEADER);
            if (err_next == bmd_pkg::ST_OK) begin
                total   = {1'b0, pos_reg} + 19'd1;
                content = {1'b0, bmd_pkg::HEADER_BYTES} + {2'd0, len_next[16:0]};
                if (total < content) begin
                    err_next = bmd_pkg::ST_TRUNCATED;
                end else begin
                    extra = total - content;
                    pad   = 2'd0 - len_next[1:0];
                    if (direction_reg ? (extra > {11'd0, max_alignment_reg})
                                      : (extra != {17'd0, pad}))
                        err_next = bmd_pkg::ST_BAD_ALIGN;
                end
            end
        end

        // Result transaction.
        res.payload_byte   = pay_valid ? b : 8'd0;
        res.payload_valid  = pay_valid;
        res.done_res       = last_byte;
        res.status         = last_byte ? err_next : bmd_pkg::ST_OK;
        res.message_tag    = last_byte ? tag_next : 8'd0;
        res.eom_attr       = last_byte ? eom_next : 1'b0;
        res.payload_length = (last_byte && err_next != bmd_pkg::ST_BAD_HEADER &&
                              err_next != bmd_pkg::ST_TOO_LONG) ?
                             len_next[16:0] : 17'd0;

        // The transfer ends here: clear for the next one.
        if (last_byte) begin
            pos_next  = '0;
            tag_next  = '0;
            len_next  = '0;
            eom_next  = 1'b0;
            err_next  = bmd_pkg::ST_OK;
            want_next = '0;
        end
    end

    assign res_push = item_acc && (pay_valid || last_byte);

    // Transfer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            tag_reg  <= '0;
            len_reg  <= '0;
            eom_reg  <= 1'b0;
            err_reg  <= bmd_pkg::ST_OK;
            want_reg <= '0;
        end else if (item_acc) begin
            pos_reg  <= pos_next;
            tag_reg  <= tag_next;
            len_reg  <= len_next;
            eom_reg  <= eom_next;
            err_reg  <= err_next;
            want_reg <= want_next;
        end
    end

    // A last byte always restarts the position count.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_acc && last_byte) |=> (pos_reg == 18'd0 && err_reg == bmd_pkg::ST_OK))
        else $error("transfer state not cleared after last byte");

    // A mid-transfer result always carries a payload byte and no verdict.
    a_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_push && !res.done_res) |-> (res.payload_valid && res.status == bmd_pkg::ST_OK))
        else $error("mid-transfer result without payload");

endmodule

/* rtl/bmd_queue.sv */
// Short result queue that decouples the parser from the output stage.
`timescale 1ns / 1ps

module bmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bmd_pkg::res_t push_data,
    input  logic          pop,
    output bmd_pkg::res_t head,
    output logic          empty,
    output logic          full
);

    bmd_pkg::res_t mem [bmd_pkg::QUEUE_DEPTH];

    logic [bmd_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [bmd_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [bmd_pkg::QCOUNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == bmd_pkg::QCOUNT_W'(bmd_pkg::QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // No write into a full queue unless an entry leaves in the same cycle, and no read from an empty one.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("result queue underflow");

endmodule

/* rtl/bmd_back.sv */
// Back end: output register that drives result transactions onto the stream.
`timescale 1ns / 1ps

module bmd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bmd_pkg::res_t                   head,
    input  logic                            empty,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    logic          out_valid_reg;
    bmd_pkg::res_t out_reg;

    // Reload whenever the register is free or being taken this cycle.
    assign pop = !empty && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pop)
            out_reg <= head;
    end

    // Pack the result fields, lowest field first, zero-filled to whole bytes.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg.payload_length, out_reg.eom_attr,
                       out_reg.message_tag, out_reg.status, out_reg.payload_byte};
    assign m_tuser  = out_reg.payload_valid;
    assign m_tlast  = out_reg.done_res;

    // A loaded result is presented on the next cycle.
    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

/* rtl/bulk_message_deframer.sv */
// Top level of the bulk message deframer: parser, result queue and output stage.
//
//  Channel   Direction  Handshake            Contents
//  s_        in         s_tvalid/s_tready    tdata: data_byte, host_tag; tlast: last_byte
//  m_        out        m_tvalid/m_tready    tdata: payload and verdict; tuser: payload_valid;
//                                            tlast: done_res
//  cfg_      in         cfg_valid/cfg_ready  cfg_index selects register, cfg_data is the value
//
// One byte is taken per cycle while the result queue is not full; the parser's per-byte
// compares and position counter decide that rate. The queue is written at the edge that
// accepts a byte, and the output register loads from the queue once it is free or being
// taken, so a result reaches m_ through the queue and then the output register.
// Reset is synchronous on aresetn low and restores the register defaults.
// s_tready drops only while the four-entry result queue is full, so the input
// side stalls only after the output side has held m_tready low for a while.
`timescale 1ns / 1ps

module bulk_message_deframer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream; tdata bits: data_byte [7:0], host_tag [15:8].
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bmd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tlast,
    // Result stream; tdata bits: payload_byte [7:0], status [10:8],
    // message_tag [18:11], eom_attr [19], payload_length [36:20], zero [39:37].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmd_pkg::M_TDATA_W-1:0]   m_tdata,
    // tuser bits: payload_valid [0].
    output logic                            m_tuser,
    output logic                            m_tlast,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bmd_pkg::CFG_DAT_W-1:0]   cfg_data
);

    logic          item_acc;
    logic          res_push;
    bmd_pkg::res_t res;
    bmd_pkg::res_t head;
    logic          q_empty;
    logic          q_full;
    logic          q_pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign item_acc  = s_tvalid && s_tready;

    // Parser.
    bmd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_acc     (item_acc),
        .data_byte    (s_tdata[7:0]),
        .last_byte    (s_tlast),
        .host_tag     (s_tdata[15:8]),
        .res_push     (res_push),
        .res          (res)
    );

    // Result queue.
    bmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Output stage.
    bmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* verif/tb_bulk_message_deframer.sv */
// Self-checking testbench for the bulk message deframer: directed and random transfers.
`timescale 1ns / 1ps

module tb_bulk_message_deframer;

    localparam int CYCLE_LIMIT   = 20_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_LIMIT   = 100;
    localparam int ITEM_TARGET   = 400;
    localparam int MIN_RANDOM    = 4;

    // Clock, reset and the signals driven into the block.
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [bmd_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          s_tlast   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [bmd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bmd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bmd_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    // Run control and bookkeeping.
    bit            steady_flow    = 1'b0;
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            bytes_sent     = 0;
    logic [7:0]    frame[$];
    bmd_pkg::res_t predicted_results[$];

    // Configuration as the block should hold it.
    logic        cfg_dir      = 1'b0;
    logic [16:0] cfg_maxpay   = 17'd65536;
    logic [7:0]  cfg_maxalign = 8'd3;

    // Per-transfer parser state.
    logic [17:0]      byte_pos  = '0;
    logic [7:0]       hdr_tag   = '0;
    logic [31:0]      msg_len   = '0;
    logic             eom_bit   = 1'b0;
    bmd_pkg::status_t fault     = bmd_pkg::ST_OK;
    logic [7:0]       want_tag  = '0;

    bulk_message_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The result side stalls at random except during steady stretches.
    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 19);
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(input string what, input longint unsigned got,
                                 input longint unsigned want, input logic known);
        if (!known || got != want)
            report_mismatch(what, got, want);
    endtask

    // Compare every accepted result transaction with the oldest prediction.
    always @(posedge aclk) begin
        bmd_pkg::res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_results.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", m_tdata, 0);
            end else begin
                want = predicted_results.pop_front();
                compare_field("payload_byte", m_tdata[7:0], want.payload_byte,
                              !$isunknown(m_tdata[7:0]));
                compare_field("payload_valid", m_tuser, want.payload_valid, !$isunknown(m_tuser));
                compare_field("done_res", m_tlast, want.done_res, !$isunknown(m_tlast));
                compare_field("status", m_tdata[10:8], want.status, !$isunknown(m_tdata[10:8]));
                compare_field("message_tag", m_tdata[18:11], want.message_tag,
                              !$isunknown(m_tdata[18:11]));
                compare_field("eom_attr", m_tdata[19], want.eom_attr,
                              !$isunknown(m_tdata[19]));
                compare_field("payload_length", m_tdata[36:20], want.payload_length,
                              !$isunknown(m_tdata[36:20]));
                compare_field("spare tdata bits", m_tdata[39:37], 0, !$isunknown(m_tdata[39:37]));
            end
        end
    end

    function automatic int pad_to_four(input logic [31:0] len);
        return (4 - int'(len[1:0])) & 3;
    endfunction

    function automatic void note_fault(input bmd_pkg::status_t code);
        if (fault == bmd_pkg::ST_OK)
            fault = code;
    endfunction

    function automatic void clear_transfer();
        byte_pos = '0;
        hdr_tag  = '0;
        msg_len  = '0;
        eom_bit  = 1'b0;
        fault    = bmd_pkg::ST_OK;
        want_tag = '0;
    endfunction

    // Work out what one accepted byte produces and queue it.
    function automatic void deframe_byte(input logic [7:0] b, input logic lst,
                                         input logic [7:0] etag);
        logic [17:0]   p;
        logic          fwd;
        logic [31:0]   lim;
        longint        total;
        longint        content;
        longint        extra;
        bmd_pkg::res_t r;
        p   = byte_pos;
        fwd = 1'b0;
        lim = (cfg_maxpay < bmd_pkg::MAX_PAYLOAD) ? 32'(cfg_maxpay) : bmd_pkg::MAX_PAYLOAD;
        // Header checks by position, then payload forwarding while no fault is known.
        if (p == 0) begin
            want_tag = etag;
            if (b != (cfg_dir ? bmd_pkg::MSG_IN_ID : bmd_pkg::MSG_OUT_ID))
                note_fault(bmd_pkg::ST_BAD_HEADER);
        end else if (p == 1) begin
            hdr_tag = b;
            if (b == 8'h00 || (cfg_dir && b != want_tag))
                note_fault(bmd_pkg::ST_BAD_HEADER);
        end else if (p == 2) begin
            if (b != ~hdr_tag)
                note_fault(bmd_pkg::ST_BAD_HEADER);
        end else if (p == 3) begin
            if (b != 8'h00)
                note_fault(bmd_pkg::ST_BAD_HEADER);
        end else if (p < 8) begin
            msg_len[8*(p-4) +: 8] = b;
        end else if (p == 8) begin
            eom_bit = b[0];
            if ((b & bmd_pkg::ATTR_RSVD_MASK) != 8'h00)
                note_fault(bmd_pkg::ST_BAD_HEADER);
        end else if (p < bmd_pkg::HEADER_BYTES) begin
            if (b != 8'h00)
                note_fault(bmd_pkg::ST_BAD_HEADER);
            if (p == bmd_pkg::HEADER_BYTES - 1 && msg_len > lim)
                note_fault(bmd_pkg::ST_TOO_LONG);
        end else if (fault == bmd_pkg::ST_OK && 32'(p - bmd_pkg::HEADER_BYTES) < msg_len) begin
            fwd = 1'b1;
        end

        if (byte_pos != bmd_pkg::POS_CAP)
            byte_pos = byte_pos + 1'b1;

        r = '0;
        // Verdict on the final byte of the transfer.
        if (lst) begin
            if (p < bmd_pkg::HEADER_BYTES - 1)
                note_fault(bmd_pkg::ST_BAD_HEADER);
            if (fault == bmd_pkg::ST_OK) begin
                total   = longint'(p) + 1;
                content = longint'(bmd_pkg::HEADER_BYTES) + longint'(msg_len);
                if (total < content) begin
                    note_fault(bmd_pkg::ST_TRUNCATED);
                end else begin
                    extra = total - content;
                    if (cfg_dir ? (extra > cfg_maxalign) : (extra != pad_to_four(msg_len)))
                        note_fault(bmd_pkg::ST_BAD_ALIGN);
                end
            end
            r.done_res    = 1'b1;
            r.status      = fault;
            r.message_tag = hdr_tag;
            r.eom_attr    = eom_bit;
            if (fault != bmd_pkg::ST_BAD_HEADER && fault != bmd_pkg::ST_TOO_LONG)
                r.payload_length = msg_len[16:0];
            clear_transfer();
        end
        if (fwd) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
        end
        if (fwd || lst)
            predicted_results.insert(predicted_results.size(), r);
    endfunction

    // Append one byte to the frame buffer.
    function automatic void frame_add(input logic [7:0] b);
        frame.insert(frame.size(), b);
    endfunction

    // Fill the frame buffer with a header, payload bytes and trailing bytes.
    function automatic void build_frame(input logic [7:0] id, input logic [7:0] tag,
                                        input logic [31:0] len, input logic [7:0] attr,
                                        input int n_body, input int n_trail);
        frame.delete();
        frame_add(id);
        frame_add(tag);
        frame_add(~tag);
        frame_add(8'h00);
        for (int i = 0; i < 4; i++)
            frame_add(len[8*i +: 8]);
        frame_add(attr);
        repeat (3) frame_add(8'h00);
        repeat (n_body) frame_add(8'($urandom));
        repeat (n_trail) frame_add(8'($urandom));
    endfunction

    function automatic void good_frame(input logic [7:0] tag, input logic [31:0] len,
                                       input logic eom, input int n_trail);
        build_frame(cfg_dir ? bmd_pkg::MSG_IN_ID : bmd_pkg::MSG_OUT_ID, tag, len,
                    {7'd0, eom}, int'(len), n_trail);
    endfunction

    function automatic void cut_frame(input int keep);
        while (frame.size() > keep)
            void'(frame.pop_back());
    endfunction

    // One input transaction, with random gaps in front of it.
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic [7:0] etag);
        while (!steady_flow && $urandom_range(0, 99) < 19) begin
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom);
            s_tlast  = 1'($urandom);
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {etag, b};
        s_tlast  = lst;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        deframe_byte(b, lst, etag);
        bytes_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Send the frame buffer as one transfer; the expected tag rides on the first byte.
    task automatic send_frame(input logic [7:0] etag);
        foreach (frame[i])
            send_byte(frame[i], i == frame.size() - 1, (i == 0) ? etag : 8'($urandom));
    endtask

    task automatic write_reg(input bmd_pkg::cfg_reg_t idx, input logic [16:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            bmd_pkg::CFG_DIRECTION:     cfg_dir      = value[0];
            bmd_pkg::CFG_MAX_PAYLOAD:   cfg_maxpay   = value;
            bmd_pkg::CFG_MAX_ALIGNMENT: cfg_maxalign = value[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Let every pending result drain and the pipeline go quiet.
    task automatic wait_quiet();
        while (predicted_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Device mode at reset defaults: good messages, every header fault, truncation, padding.
    task automatic test_device_directed();
        good_frame(8'h01, 0, 1'b1, 0);
        send_frame(8'h00);
        good_frame(8'h80, 5, 1'b1, 3);
        frame[12] = 8'h00;
        frame[13] = 8'hFF;
        send_frame(8'h5A);
        // One byte past the pad, then a missing pad byte.
        good_frame(8'h7F, 4, 1'b0, 1);
        send_frame(8'hA5);
        good_frame(8'h11, 3, 1'b0, 0);
        send_frame(8'h11);
        // Truncated payload: bytes are forwarded before the verdict.
        good_frame(8'h22, 10, 1'b0, 2);
        cut_frame(18);
        send_frame(8'h22);
        // Short transfers that end inside the header.
        good_frame(8'h12, 0, 1'b0, 0);
        cut_frame(1);
        send_frame(8'h12);
        good_frame(8'h55, 0, 1'b0, 0);
        cut_frame(2);
        send_frame(8'h55);
        good_frame(8'h44, 0, 1'b1, 0);
        cut_frame(9);
        send_frame(8'h44);
        good_frame(8'h33, 0, 1'b1, 0);
        cut_frame(11);
        send_frame(8'h33);
        // Header faults; the first one latches and blocks forwarding.
        good_frame(8'h66, 4, 1'b0, 0);
        frame[0] = bmd_pkg::MSG_IN_ID;
        send_frame(8'h66);
        good_frame(8'h00, 0, 1'b0, 0);
        send_frame(8'h00);
        good_frame(8'h9C, 0, 1'b0, 0);
        frame[2] ^= 8'h01;
        send_frame(8'h9C);
        good_frame(8'h9D, 0, 1'b0, 0);
        frame[3] = 8'h80;
        send_frame(8'h9D);
        good_frame(8'h9E, 0, 1'b1, 0);
        frame[8] = 8'h81;
        send_frame(8'h9E);
        // Length above the limit, alone and behind a header fault.
        build_frame(bmd_pkg::MSG_OUT_ID, 8'h77, 32'd65537, 8'h00, 0, 0);
        send_frame(8'h77);
        build_frame(bmd_pkg::MSG_OUT_ID, 8'h78, 32'd65537, 8'h00, 0, 0);
        frame[11] = 8'h04;
        send_frame(8'h78);
    endtask

    // Host mode without idling: tag matching and the alignment allowance.
    task automatic test_host_mode();
        wait_quiet();
        write_reg(bmd_pkg::CFG_DIRECTION, 17'd1);
        write_reg(bmd_pkg::CFG_MAX_ALIGNMENT, 17'd0);
        steady_flow = 1'b1;
        good_frame(8'hA5, 3, 1'b1, 0);
        send_frame(8'hA5);
        good_frame(8'hA5, 3, 1'b1, 1);
        send_frame(8'hA5);
        wait_quiet();
        write_reg(bmd_pkg::CFG_MAX_ALIGNMENT, 17'd255);
        good_frame(8'h01, 2, 1'b0, 9);
        send_frame(8'h01);
        wait_quiet();
        write_reg(bmd_pkg::CFG_MAX_ALIGNMENT, 17'd3);
        good_frame(8'h3C, 3, 1'b0, 2);
        send_frame(8'h3C);
        good_frame(8'h3C, 3, 1'b0, 0);
        send_frame(8'hC3);
        build_frame(bmd_pkg::MSG_OUT_ID, 8'h42, 32'd0, 8'h00, 0, 0);
        send_frame(8'h42);
        good_frame(8'h43, 6, 1'b1, 0);
        cut_frame(15);
        send_frame(8'h43);
        steady_flow = 1'b0;
        wait_quiet();
        write_reg(bmd_pkg::CFG_DIRECTION, 17'd0);
    endtask

    // Payload limit at both extremes.
    task automatic test_length_limit();
        wait_quiet();
        write_reg(bmd_pkg::CFG_MAX_PAYLOAD, 17'd0);
        good_frame(8'h01, 0, 1'b1, 0);
        send_frame(8'h01);
        good_frame(8'h02, 1, 1'b0, 0);
        send_frame(8'h02);
        wait_quiet();
        write_reg(bmd_pkg::CFG_MAX_PAYLOAD, 17'd65536);
        build_frame(bmd_pkg::MSG_OUT_ID, 8'h5A, 32'd65537, 8'h01, 0, 0);
        send_frame(8'h5A);
    endtask

    task automatic random_config();
        logic [16:0] maxpay;
        logic [7:0]  maxalign;
        case ($urandom_range(0, 3))
            0:       maxpay = 17'd0;
            1:       maxpay = 17'($urandom_range(1, 40));
            2:       maxpay = 17'd65536;
            default: maxpay = 17'($urandom_range(0, 65536));
        endcase
        case ($urandom_range(0, 3))
            0:       maxalign = 8'd0;
            1:       maxalign = 8'd2;
            2:       maxalign = 8'd3;
            default: maxalign = 8'($urandom_range(0, 7));
        endcase
        write_reg(bmd_pkg::CFG_DIRECTION, 17'($urandom_range(0, 1)));
        write_reg(bmd_pkg::CFG_MAX_PAYLOAD, maxpay);
        write_reg(bmd_pkg::CFG_MAX_ALIGNMENT, 17'(maxalign));
    endtask

    // Mostly well-formed messages with random content; the rest broken or pure noise.
    task automatic random_transfer();
        logic [7:0]  tag;
        logic [7:0]  etag;
        logic [31:0] len;
        logic [31:0] lim;
        int          n_body;
        int          n_trail;
        int          k;
        tag  = 8'($urandom_range(1, 255));
        etag = ($urandom_range(0, 9) != 0) ? tag : 8'($urandom);
        lim  = (cfg_maxpay < bmd_pkg::MAX_PAYLOAD) ? 32'(cfg_maxpay) : bmd_pkg::MAX_PAYLOAD;
        if ($urandom_range(0, 9) == 0) begin
            len    = lim + 1;
            n_body = 0;
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
            n_body = int'(len);
        end
        if (!cfg_dir) begin
            n_trail = pad_to_four(len);
        end else begin
            case ($urandom_range(0, 4))
                0:       n_trail = int'(cfg_maxalign);
                1:       n_trail = int'(cfg_maxalign) + 1;
                default: n_trail = $urandom_range(0, 3);
            endcase
        end
        build_frame(cfg_dir ? bmd_pkg::MSG_IN_ID : bmd_pkg::MSG_OUT_ID, tag, len,
                    {7'd0, 1'($urandom)}, n_body, n_trail);
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 5))
                0: begin
                    k = $urandom_range(0, 11);
                    frame[k] ^= 8'(1 << $urandom_range(0, 7));
                end
                1: cut_frame($urandom_range(1, frame.size() - 1));
                2: repeat ($urandom_range(1, 5)) frame_add(8'($urandom));
                3: begin
                    frame.delete();
                    repeat ($urandom_range(1, 30)) frame_add(8'($urandom));
                    if ($urandom_range(0, 1) == 1)
                        frame[0] = cfg_dir ? bmd_pkg::MSG_IN_ID : bmd_pkg::MSG_OUT_ID;
                end
                4: etag ^= 8'($urandom_range(1, 255));
                default: begin
                    if (frame.size() > 12)
                        frame[$urandom_range(12, frame.size() - 1)] = 8'($urandom);
                end
            endcase
        end
        send_frame(etag);
    endtask

    // Random transfers under a few random settings until the byte budget is used and at least MIN_RANDOM transfers ran.
    task automatic test_random();
        int transfers;
        transfers = 0;
        while (bytes_sent < ITEM_TARGET || transfers < MIN_RANDOM) begin
            if (transfers % 2 == 0) begin
                wait_quiet();
                random_config();
            end
            random_transfer();
            transfers++;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_device_directed();
        test_host_mode();
        test_length_limit();
        test_random();

        wait_quiet();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
